// File: rtl/core/cbsp_pkg.sv
// ----------------------------------------------------------------------------
// cbsp_pkg
// Shared constants and types for the clocked bit-serial physical layer.
// ----------------------------------------------------------------------------
package cbsp_pkg;

  // Number of bits that make up one serial word.
  localparam int BITS_PER_WORD = 8;

  // Width of the byte-wide data paths.
  localparam int BYTE_W = 8;

  // Bit index counter width; it counts 0 .. BITS_PER_WORD-1.
  localparam int IDX_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;

  // Last bit index of a word.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS_PER_WORD - 1);

  // Byte handed from the interface to the transmitter on a falling
  // interface-clock edge with a request.
  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] data;
  } tx_load_t;

  // Completed byte held by the receiver until the interface presents it.
  typedef struct packed {
    logic              have;
    logic [BYTE_W-1:0] data;
  } rx_status_t;

endpackage

// File: rtl/core/clocked_bit_serial_phy.sv
// ----------------------------------------------------------------------------
// clocked_bit_serial_phy
// Byte-wide bit-serial physical layer driven by sampled pin levels.
//
//   Channel  Direction  Handshake            Payload
//   in       to block   in_valid / in_stall   tx_clock_level, rx_clock_level,
//                                             rx_line, iface_clock_level,
//                                             tx_request, tx_byte
//   out      from block out_valid / out_stall tx_line, rx_ready, rx_byte,
//                                             busy_res
//
// Each sample moves from the input register into the interface, transmit and
// receive state, whose pin registers are the result. A new sample is taken
// every cycle unless the input stalls.
// Synchronous reset clears both valid flags and all state but sampled inputs.
// A stall on the output holds the result and the sample waiting behind it;
// the input stalls only when both are full.
// ----------------------------------------------------------------------------
module clocked_bit_serial_phy (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        tx_clock_level,
  input  logic                        rx_clock_level,
  input  logic                        rx_line,
  input  logic                        iface_clock_level,
  input  logic                        tx_request,
  input  logic [cbsp_pkg::BYTE_W-1:0] tx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        tx_line,
  output logic                        rx_ready,
  output logic [cbsp_pkg::BYTE_W-1:0] rx_byte,
  output logic                        busy_res
);

  logic                        s_valid;
  logic                        s_tx_clock;
  logic                        s_rx_clock;
  logic                        s_rx_line;
  logic                        s_iface_clock;
  logic                        s_request;
  logic [cbsp_pkg::BYTE_W-1:0] s_byte;

  logic                        step;
  logic                        tx_busy;
  logic                        rx_take;
  cbsp_pkg::tx_load_t          tx_load;
  cbsp_pkg::rx_status_t        rx_status;

  // A held sample is processed whenever the result register is free.
  assign step     = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !step;

  // Input sample register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s_tx_clock    <= tx_clock_level;
      s_rx_clock    <= rx_clock_level;
      s_rx_line     <= rx_line;
      s_iface_clock <= iface_clock_level;
      s_request     <= tx_request;
      s_byte        <= tx_byte;
    end
  end

  // Result valid flag; the pin registers in the units hold the payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s_valid;
    end
  end

  cbsp_iface u_iface (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .iface_clock_level (s_iface_clock),
    .tx_request        (s_request),
    .tx_byte           (s_byte),
    .tx_busy           (tx_busy),
    .rx_status         (rx_status),
    .tx_load           (tx_load),
    .rx_take           (rx_take),
    .rx_ready          (rx_ready),
    .rx_byte           (rx_byte),
    .busy_res          (busy_res)
  );

  cbsp_tx u_tx (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .tx_clock_level (s_tx_clock),
    .tx_load        (tx_load),
    .tx_busy        (tx_busy),
    .tx_line        (tx_line)
  );

  cbsp_rx u_rx (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_clock_level (s_rx_clock),
    .rx_line        (s_rx_line),
    .rx_take        (rx_take),
    .rx_status      (rx_status)
  );

endmodule

// File: rtl/core/cbsp_iface.sv
// ----------------------------------------------------------------------------
// cbsp_iface
// Upper-layer interface: detects interface-clock edges, passes a byte to the
// transmitter on a falling edge and presents receive status on a rising edge.
// ----------------------------------------------------------------------------
module cbsp_iface (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           iface_clock_level,
  input  logic                           tx_request,
  input  logic [cbsp_pkg::BYTE_W-1:0]    tx_byte,
  input  logic                           tx_busy,
  input  cbsp_pkg::rx_status_t           rx_status,
  output cbsp_pkg::tx_load_t             tx_load,
  output logic                           rx_take,
  output logic                           rx_ready,
  output logic [cbsp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                           busy_res
);

  logic iface_clock_prev;
  logic rise;
  logic fall;

  // Edge detection against the previous sample.
  assign rise = !iface_clock_prev && iface_clock_level;
  assign fall = iface_clock_prev && !iface_clock_level;

  // A falling edge with a request hands the byte to the transmitter.
  assign tx_load.load = step && fall && tx_request;
  assign tx_load.data = tx_byte;

  // A rising edge consumes a held received byte.
  assign rx_take = step && rise && rx_status.have;

  // Edge history and presented status.
  always_ff @(posedge clk) begin
    if (rst) begin
      iface_clock_prev <= 1'b0;
      rx_ready         <= 1'b0;
      rx_byte          <= '0;
      busy_res         <= 1'b0;
    end else if (step) begin
      iface_clock_prev <= iface_clock_level;
      if (rise) begin
        rx_ready <= rx_status.have;
        busy_res <= tx_busy;
        if (rx_status.have) begin
          rx_byte <= rx_status.data;
        end
      end
    end
  end

endmodule

// File: rtl/core/cbsp_tx.sv
// ----------------------------------------------------------------------------
// cbsp_tx
// Transmitter: loads a byte from the interface and shifts it out MSB first,
// one bit per rising transmit-clock edge.
// ----------------------------------------------------------------------------
module cbsp_tx (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 tx_clock_level,
  input  cbsp_pkg::tx_load_t   tx_load,
  output logic                 tx_busy,
  output logic                 tx_line
);

  logic [cbsp_pkg::BYTE_W-1:0] tx_shift;
  logic [cbsp_pkg::IDX_W-1:0]  tx_bit_index;
  logic                        tx_active;
  logic                        tx_clock_prev;

  logic [cbsp_pkg::BYTE_W-1:0] shift_ld;
  logic [cbsp_pkg::IDX_W-1:0]  index_ld;
  logic                        active_ld;
  logic                        shift_en;

  // A load replaces the byte and restarts the bit index in the same sample.
  assign shift_ld  = tx_load.load ? tx_load.data : tx_shift;
  assign index_ld  = tx_load.load ? '0 : tx_bit_index;
  assign active_ld = tx_load.load || tx_active;
  assign shift_en  = active_ld && !tx_clock_prev && tx_clock_level;

  assign tx_busy = tx_active;

  // Shift register, bit counter and line driver.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift      <= '0;
      tx_bit_index  <= '0;
      tx_active     <= 1'b0;
      tx_clock_prev <= 1'b0;
      tx_line       <= 1'b0;
    end else if (step) begin
      tx_clock_prev <= tx_clock_level;
      if (shift_en) begin
        tx_line  <= shift_ld[cbsp_pkg::BYTE_W-1];
        tx_shift <= {shift_ld[cbsp_pkg::BYTE_W-2:0], 1'b0};
        if (index_ld == cbsp_pkg::LAST_IDX) begin
          tx_active    <= 1'b0;
          tx_bit_index <= '0;
        end else begin
          tx_active    <= 1'b1;
          tx_bit_index <= index_ld + 1'b1;
        end
      end else begin
        tx_shift     <= shift_ld;
        tx_active    <= active_ld;
        tx_bit_index <= index_ld;
      end
    end
  end

endmodule

// File: rtl/core/cbsp_rx.sv
// ----------------------------------------------------------------------------
// cbsp_rx
// Receiver: samples the data line MSB first on each falling receive-clock
// edge and holds each completed byte until the interface takes it.
// ----------------------------------------------------------------------------
module cbsp_rx (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   rx_clock_level,
  input  logic                   rx_line,
  input  logic                   rx_take,
  output cbsp_pkg::rx_status_t   rx_status
);

  logic [cbsp_pkg::BYTE_W-1:0] rx_shift;
  logic [cbsp_pkg::IDX_W-1:0]  rx_bit_index;
  logic                        rx_clock_prev;
  logic                        rx_have_byte;
  logic [cbsp_pkg::BYTE_W-1:0] rx_held_byte;

  logic                        sample;
  logic [cbsp_pkg::BYTE_W-1:0] shift_next;

  assign sample     = rx_clock_prev && !rx_clock_level;
  assign shift_next = {rx_shift[cbsp_pkg::BYTE_W-2:0], rx_line};

  assign rx_status.have = rx_have_byte;
  assign rx_status.data = rx_held_byte;

  // Shift in, count bits and hold the finished byte. A byte completed in the
  // same sample as a take stays held for the next presentation.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_shift      <= '0;
      rx_bit_index  <= '0;
      rx_clock_prev <= 1'b0;
      rx_have_byte  <= 1'b0;
      rx_held_byte  <= '0;
    end else if (step) begin
      rx_clock_prev <= rx_clock_level;
      if (sample && rx_bit_index == cbsp_pkg::LAST_IDX) begin
        rx_held_byte <= shift_next;
        rx_have_byte <= 1'b1;
        rx_shift     <= '0;
        rx_bit_index <= '0;
      end else begin
        if (rx_take) begin
          rx_have_byte <= 1'b0;
        end
        if (sample) begin
          rx_shift     <= shift_next;
          rx_bit_index <= rx_bit_index + 1'b1;
        end
      end
    end
  end

endmodule
